// ===== hw/rtl/lsra_pkg.sv =====
package lsra_pkg;

  localparam int NUM_REGS_DEF = 16;
  localparam int MAX_REGS     = 16;
  localparam int ID_W         = 16;
  localparam int POS_W        = 16;
  localparam int REG_W        = 4;
  localparam int SLOT_W       = 16;

  localparam logic [SLOT_W-1:0] SLOT_MAX = {SLOT_W{1'b1}};

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_SHIFT,
    CELL_INSERT
  } cell_op_t;

  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  id;
    logic [POS_W-1:0] end_pos;
    logic [REG_W-1:0] rg;
  } cell_t;

  typedef struct packed {
    cell_op_t op;
    cell_t    ins;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

// ===== hw/rtl/lsra_cell.sv =====
module lsra_cell
  import lsra_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  logic      kill,
  input  cell_t     left,
  input  logic      left_open,
  input  cell_t     right,
  output cell_t     q,
  output logic      open
);

  logic             valid;
  logic [ID_W-1:0]  id;
  logic [POS_W-1:0] end_pos;
  logic [REG_W-1:0] rg;
  cell_t            q_next;

  assign q = '{valid: valid, id: id, end_pos: end_pos, rg: rg};

  // A cell is open when the new interval belongs at or before it. A killed cell
  // (the evicted top) counts as empty.
  assign open = !(valid && !kill) || (end_pos > ctl.ins.end_pos);

  always_comb begin
    q_next = q;
    unique case (ctl.op)
      CELL_HOLD: begin
        q_next = q;
      end
      CELL_CLEAR: begin
        q_next.valid = 1'b0;
      end
      CELL_SHIFT: begin
        q_next = right;
      end
      CELL_INSERT: begin
        if (left_open) begin
          q_next = left;
        end else if (open) begin
          q_next = ctl.ins;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= q_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    id      <= q_next.id;
    end_pos <= q_next.end_pos;
    rg      <= q_next.rg;
  end

endmodule

// ===== hw/rtl/linear_scan_register_allocator_core.sv =====
// Channel | Direction | Handshake               | Beat payload
// input   | in        | in_valid / in_ready     | interval_id, interval_start, interval_end,
//         |           |                         | start_new
// result  | out       | out_valid / out_ready   | result_id, is_spilled, reg_index,
//         |           |                         | spill_slot, slot_overflow, last
// config  | in        | cfg_write_en            | cfg_write_data (spill_slot_base)
//
// For each interval the chain of cells first retires the expired active
// intervals from its head, one per cycle; once the output stage can take a beat
// it inserts the interval (evicting the furthest-ending cell if full) or spills it.
// Synchronous reset empties the cells, frees all registers and loads the spill
// counter and its base with zero.
// An eviction yields two result beats; allocation waits while the output stage
// still holds a beat that cannot drain, and input is taken only between items.
module linear_scan_register_allocator_core
  import lsra_pkg::*;
#(
  parameter int NUM_REGS = NUM_REGS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ID_W-1:0]   interval_id,
  input  logic [POS_W-1:0]  interval_start,
  input  logic [POS_W-1:0]  interval_end,
  input  logic              start_new,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ID_W-1:0]   result_id,
  output logic              is_spilled,
  output logic [REG_W-1:0]  reg_index,
  output logic [SLOT_W-1:0] spill_slot,
  output logic              slot_overflow,
  output logic              last,
  input  logic              cfg_write_en,
  input  logic [SLOT_W-1:0] cfg_write_data
);

  localparam int REG_CAP = (NUM_REGS > MAX_REGS) ? MAX_REGS : NUM_REGS;

  state_t state, state_next;

  logic [ID_W-1:0]   cur_id;
  logic [POS_W-1:0]  cur_start;
  logic [POS_W-1:0]  cur_end;
  logic [SLOT_W-1:0] spill_base;
  logic [SLOT_W-1:0] spill_counter;
  logic [REG_CAP-1:0] free_map, free_map_next;

  logic              pend_valid;
  logic [ID_W-1:0]   pend_id;
  logic [SLOT_W-1:0] pend_slot;
  logic              pend_ovf;

  cell_ctl_t         ctl;
  cell_t             cells [REG_CAP];
  logic [REG_CAP-1:0] cell_open;
  logic [REG_CAP-1:0] cell_valid;

  logic              accept;
  logic              expire;
  logic              full;
  logic              evict;
  logic              can_emit;
  logic              do_alloc;
  logic [REG_W-1:0]  low_free;
  logic              slot_ovf;

  genvar g;
  generate
    for (g = 0; g < REG_CAP; g++) begin : g_cell
      cell_t left_q, right_q;
      logic  left_op;
      logic  kill_q;

      if (g == 0) begin : g_head
        assign left_q  = '0;
        assign left_op = 1'b0;
      end else begin : g_body
        assign left_q  = cells[g-1];
        assign left_op = cell_open[g-1];
      end

      if (g == REG_CAP - 1) begin : g_tail
        assign right_q = '0;
        assign kill_q  = evict;
      end else begin : g_mid
        assign right_q = cells[g+1];
        assign kill_q  = 1'b0;
      end

      lsra_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .kill      (kill_q),
        .left      (left_q),
        .left_open (left_op),
        .right     (right_q),
        .q         (cells[g]),
        .open      (cell_open[g])
      );

      assign cell_valid[g] = cells[g].valid;
    end
  endgenerate

  assign accept   = in_valid && in_ready;
  assign expire   = cells[0].valid && (cells[0].end_pos <= cur_start);
  assign full     = cell_valid[REG_CAP-1];
  assign evict    = full && (cells[REG_CAP-1].end_pos > cur_end);
  assign can_emit = (!out_valid || out_ready) && !pend_valid;
  assign slot_ovf = (spill_counter == SLOT_MAX);

  always_comb begin
    low_free = '0;
    for (int i = REG_CAP - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        low_free = REG_W'(i);
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (do_alloc) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready       = 1'b0;
    do_alloc       = 1'b0;
    ctl.op         = CELL_HOLD;
    ctl.ins.valid  = 1'b1;
    ctl.ins.id     = cur_id;
    ctl.ins.end_pos = cur_end;
    ctl.ins.rg     = full ? cells[REG_CAP-1].rg : low_free;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && start_new) begin
          ctl.op = CELL_CLEAR;
        end
      end
      ST_SCAN: begin
        if (expire) begin
          ctl.op = CELL_SHIFT;
        end else if (can_emit) begin
          do_alloc = 1'b1;
          if (!full || evict) begin
            ctl.op = CELL_INSERT;
          end
        end
      end
    endcase
  end

  always_comb begin
    free_map_next = free_map;
    if (accept && start_new) begin
      free_map_next = '1;
    end else if (state == ST_SCAN && expire) begin
      for (int i = 0; i < REG_CAP; i++) begin
        if (cells[0].rg == REG_W'(i)) begin
          free_map_next[i] = 1'b1;
        end
      end
    end else if (do_alloc && !full) begin
      for (int i = 0; i < REG_CAP; i++) begin
        if (low_free == REG_W'(i)) begin
          free_map_next[i] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      free_map      <= '1;
      spill_base    <= '0;
      spill_counter <= '0;
      out_valid     <= 1'b0;
      pend_valid    <= 1'b0;
    end else begin
      state    <= state_next;
      free_map <= free_map_next;
      if (cfg_write_en) begin
        spill_base <= cfg_write_data;
      end
      if (accept && start_new) begin
        spill_counter <= spill_base;
      end else if (do_alloc && full && !slot_ovf) begin
        spill_counter <= spill_counter + 1'b1;
      end
      if (do_alloc) begin
        out_valid  <= 1'b1;
        pend_valid <= evict;
      end else if (out_valid && out_ready) begin
        out_valid  <= pend_valid;
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_id    <= interval_id;
      cur_start <= interval_start;
      cur_end   <= interval_end;
    end
    if (do_alloc) begin
      result_id <= cur_id;
      if (!full || evict) begin
        is_spilled    <= 1'b0;
        reg_index     <= ctl.ins.rg;
        spill_slot    <= '0;
        slot_overflow <= 1'b0;
        last          <= !evict;
      end else begin
        is_spilled    <= 1'b1;
        reg_index     <= '0;
        spill_slot    <= spill_counter;
        slot_overflow <= slot_ovf;
        last          <= 1'b1;
      end
      pend_id   <= cells[REG_CAP-1].id;
      pend_slot <= spill_counter;
      pend_ovf  <= slot_ovf;
    end else if (out_valid && out_ready && pend_valid) begin
      result_id     <= pend_id;
      is_spilled    <= 1'b1;
      reg_index     <= '0;
      spill_slot    <= pend_slot;
      slot_overflow <= pend_ovf;
      last          <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  // Every usable register is either free or held by exactly one active cell.
  a_reg_conservation: assert property (@(posedge clk) disable iff (rst)
    ($countones(free_map) + $countones(cell_valid)) == REG_CAP)
    else $error("free map and active cells disagree");

  // The evicted interval's beat waits behind the first beat of an eviction.
  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (out_valid && !last))
    else $error("pending beat without a first eviction beat");

  a_first_has_pend: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> pend_valid)
    else $error("eviction beat lost its second beat");

  // A new item is never taken while the chain is still working on one.
  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !in_ready)
    else $error("input taken during scan");
`endif

endmodule
